@@ rtl/core/run_length_byte_decoder_defines.svh @@
// Assertion macros shared by the run-length byte decoder modules.
`ifndef RUN_LENGTH_BYTE_DECODER_DEFINES_SVH
`define RUN_LENGTH_BYTE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RLD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RLD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/rld_pkg.sv @@
// Shared types and constants of the run-length byte decoder.
`default_nettype none
package rld_pkg;

   localparam int unsigned LimitWidth = 32;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CountWidth = 7;
   localparam int unsigned PairWidth  = 16;
   localparam int unsigned VcntWidth  = 2;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned RspDataWidth = 24;

   // Register map.
   localparam logic [CsrAddrWidth-1:0] CSR_OUTPUT_LIMIT = 3'h0;

   // Control byte fields.
   localparam logic [ByteWidth-1:0]  RUN_FLAG   = 8'h80;
   localparam logic [ByteWidth-1:0]  COUNT_MASK = 8'h7F;

   // Decode phases.
   localparam logic [1:0] PH_CTRL   = 2'd0;
   localparam logic [1:0] PH_RUNVAL = 2'd1;
   localparam logic [1:0] PH_LIT    = 2'd2;

   // Controller states.
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_item;
      logic emit_pair;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic start_run;
      logic last_pair;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/core/rld_ctrl.sv @@
// Controller state machine of the run-length byte decoder.
`default_nettype none
`include "run_length_byte_decoder_defines.svh"
module rld_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  rld_pkg::status_type  status,
   output rld_pkg::cmd_type     cmd
);

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      cmd.take_item = 1'b0;
      cmd.emit_pair = 1'b0;
      unique case (state_ff)
         rld_pkg::ST_IDLE: begin
            req_tready    = status.out_free;
            cmd.take_item = req_tvalid && status.out_free;
            if (cmd.take_item && status.start_run) begin
               state_in = rld_pkg::ST_RUN;
            end
         end
         rld_pkg::ST_RUN: begin
            cmd.emit_pair = status.out_free;
            if (status.out_free && status.last_pair) begin
               state_in = rld_pkg::ST_IDLE;
            end
         end
         default: state_in = rld_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rld_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `RLD_ASSERT_NOW(a_no_take_in_run, clock, reset, state_ff == rld_pkg::ST_RUN, !req_tready, "input taken during a run")
   `RLD_ASSERT_NEXT(a_run_ends, clock, reset, cmd.emit_pair && status.last_pair, state_ff == rld_pkg::ST_IDLE, "run did not end after its last pair")

endmodule
`default_nettype wire

@@ rtl/core/rld_dp.sv @@
// Datapath of the run-length byte decoder: decode state, run counter and result register.
`default_nettype none
`include "run_length_byte_decoder_defines.svh"
module rld_dp (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  [rld_pkg::ByteWidth-1:0]        data_byte,
   input  wire                                  stream_end,
   input  wire  [rld_pkg::LimitWidth-1:0]       output_limit,
   input  rld_pkg::cmd_type                     cmd,
   output rld_pkg::status_type                  status,
   input  wire                                  rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [rld_pkg::PairWidth-1:0]        out_pair,
   output logic [rld_pkg::VcntWidth-1:0]        out_valid_count,
   output logic                                 out_last,
   output logic                                 limit_reached
);

   logic [1:0]                      phase_ff, phase_in;
   logic [rld_pkg::CountWidth-1:0]  pend_ff, pend_in;
   logic [rld_pkg::LimitWidth-1:0]  prod_ff, prod_in;
   logic [rld_pkg::CountWidth-1:0]  run_len_ff, run_len_in;
   logic [rld_pkg::ByteWidth-1:0]   run_val_ff, run_val_in;
   logic                            run_end_ff, run_end_in;

   logic                            vld_ff, vld_in;
   logic [rld_pkg::PairWidth-1:0]   pair_ff, pair_in;
   logic [rld_pkg::VcntWidth-1:0]   vcnt_ff, vcnt_in;
   logic                            last_ff, last_in;
   logic                            lim_ff, lim_in;

   logic                            active;
   logic [rld_pkg::LimitWidth-1:0]  room;
   logic [rld_pkg::CountWidth-1:0]  run_len;
   logic                            two;
   logic [rld_pkg::LimitWidth-1:0]  prod_inc;

   // Bytes still allowed and the run length clipped to them.
   assign active  = prod_ff < output_limit;
   assign room    = output_limit - prod_ff;
   assign run_len = (room < {{(rld_pkg::LimitWidth-rld_pkg::CountWidth){1'b0}}, pend_ff})
                  ? room[rld_pkg::CountWidth-1:0] : pend_ff;
   assign two     = run_len_ff >= rld_pkg::CountWidth'(2);
   assign prod_inc = cmd.emit_pair
                   ? prod_ff + (two ? rld_pkg::LimitWidth'(2) : rld_pkg::LimitWidth'(1))
                   : prod_ff + rld_pkg::LimitWidth'(1);

   assign status.out_free  = !vld_ff || rsp_tready;
   assign status.start_run = active && (phase_ff == rld_pkg::PH_RUNVAL) && (run_len != '0);
   assign status.last_pair = run_len_ff <= rld_pkg::CountWidth'(2);

   always_comb begin
      phase_in   = phase_ff;
      pend_in    = pend_ff;
      prod_in    = prod_ff;
      run_len_in = run_len_ff;
      run_val_in = run_val_ff;
      run_end_in = run_end_ff;
      vld_in     = vld_ff && !rsp_tready;
      pair_in    = pair_ff;
      vcnt_in    = vcnt_ff;
      last_in    = last_ff;
      lim_in     = lim_ff;

      if (cmd.take_item) begin
         if (active) begin
            case (phase_ff)
               rld_pkg::PH_RUNVAL: begin
                  run_len_in = run_len;
                  run_val_in = data_byte;
                  run_end_in = stream_end;
                  phase_in   = rld_pkg::PH_CTRL;
                  pend_in    = '0;
               end
               rld_pkg::PH_LIT: begin
                  vld_in   = 1'b1;
                  pair_in  = {{(rld_pkg::PairWidth-rld_pkg::ByteWidth){1'b0}}, data_byte};
                  vcnt_in  = rld_pkg::VcntWidth'(1);
                  last_in  = 1'b1;
                  lim_in   = prod_inc == output_limit;
                  prod_in  = prod_inc;
                  pend_in  = pend_ff - rld_pkg::CountWidth'(1);
                  if (pend_in == '0) begin
                     phase_in = rld_pkg::PH_CTRL;
                  end
               end
               default: begin
                  pend_in = rld_pkg::CountWidth'(data_byte & rld_pkg::COUNT_MASK);
                  if ((data_byte & rld_pkg::RUN_FLAG) != '0) begin
                     phase_in = rld_pkg::PH_RUNVAL;
                  end else if (pend_in != '0) begin
                     phase_in = rld_pkg::PH_LIT;
                  end else begin
                     phase_in = rld_pkg::PH_CTRL;
                  end
               end
            endcase
         end
         // End of stream clears the state; a run in flight clears the byte count at its end.
         if (stream_end) begin
            phase_in = rld_pkg::PH_CTRL;
            pend_in  = '0;
            if (!status.start_run) begin
               prod_in = '0;
            end
         end
      end

      if (cmd.emit_pair) begin
         vld_in     = 1'b1;
         pair_in    = two ? {run_val_ff, run_val_ff}
                          : {{(rld_pkg::PairWidth-rld_pkg::ByteWidth){1'b0}}, run_val_ff};
         vcnt_in    = two ? rld_pkg::VcntWidth'(2) : rld_pkg::VcntWidth'(1);
         last_in    = status.last_pair;
         lim_in     = prod_inc == output_limit;
         run_len_in = two ? run_len_ff - rld_pkg::CountWidth'(2) : '0;
         prod_in    = (status.last_pair && run_end_ff) ? '0 : prod_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= rld_pkg::PH_CTRL;
         pend_ff    <= '0;
         prod_ff    <= '0;
         run_len_ff <= '0;
         run_end_ff <= 1'b0;
         vld_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pend_ff    <= pend_in;
         prod_ff    <= prod_in;
         run_len_ff <= run_len_in;
         run_end_ff <= run_end_in;
         vld_ff     <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      run_val_ff <= run_val_in;
      pair_ff    <= pair_in;
      vcnt_ff    <= vcnt_in;
      last_ff    <= last_in;
      lim_ff     <= lim_in;
   end

   assign rsp_tvalid      = vld_ff;
   assign out_pair        = pair_ff;
   assign out_valid_count = vcnt_ff;
   assign out_last        = last_ff;
   assign limit_reached   = lim_ff;

   `RLD_ASSERT_NOW(a_emit_has_bytes, clock, reset, cmd.emit_pair, run_len_ff != '0, "pair emitted from an empty run")
   `RLD_ASSERT_NOW(a_vcnt_range, clock, reset, vld_ff, (vcnt_ff == 2'd1) || (vcnt_ff == 2'd2), "result byte count out of range")
   `RLD_ASSERT_NOW(a_one_source, clock, reset, cmd.take_item, !cmd.emit_pair, "input taken while a run emits")

endmodule
`default_nettype wire

@@ rtl/core/run_length_byte_decoder.sv @@
// Top level of the run-length byte decoder with its configuration register.
// Usage:
// Compressed bytes enter on the req_ stream, one byte per beat, with tlast set on
// the final byte of a stream. Decoded bytes leave on the rsp_ stream as results
// of one or two bytes each. A literal byte's result is loaded at the edge that
// accepts its beat and is presented in the next cycle; a new literal byte can be
// taken every cycle while the rsp_ side does not stall. A run value byte yields
// ceil(n/2) results, one per cycle unless the rsp_ side stalls, n being the run
// length clipped to the remaining output budget. The value beat loads the run
// counter and enters the run state, which loads the pairs. No input beat
// is taken until the last pair has been loaded. Control bytes yield no result.
// The output_limit register (APB, byte address 0) caps the decoded bytes per
// stream; once reached, input beats are taken and dropped until tlast. Write it
// only while the decoder is idle.
// A single result register sits between the decode logic and the rsp_ side, so a
// stall there holds the current result and blocks new work only when that
// register is still full. Reset clears the decode state, the byte count, the
// result valid flag and output_limit; the decoder is ready when reset is released.
`default_nettype none
module run_length_byte_decoder (
   input  wire                                 clock,
   input  wire                                 reset,
   // Input stream.
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [7:0]                          req_tdata,   // [7:0] data_byte
   input  wire                                 req_tlast,   // stream_end
   // Result stream.
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [rld_pkg::RspDataWidth-1:0]    rsp_tdata,   // [15:0] out_pair,
                                                            // [17:16] out_valid_count,
                                                            // [23:18] zero
   output logic                                rsp_tlast,   // out_last
   output logic                                rsp_tuser,   // limit_reached
   // Configuration port.
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [rld_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  wire  [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic [rld_pkg::LimitWidth-1:0] limit_ff, limit_in;
   rld_pkg::cmd_type               cmd;
   rld_pkg::status_type            status;
   logic [rld_pkg::PairWidth-1:0]  out_pair;
   logic [rld_pkg::VcntWidth-1:0]  out_valid_count;

   // The register takes the write in the access phase; pready is tied high.
   assign csr_pready = 1'b1;

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == rld_pkg::CSR_OUTPUT_LIMIT)) begin
         limit_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // Reads return the limit at its address and zero elsewhere.
   assign csr_prdata = (csr_paddr == rld_pkg::CSR_OUTPUT_LIMIT) ? limit_ff : '0;

   rld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rld_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .data_byte       (req_tdata),
      .stream_end      (req_tlast),
      .output_limit    (limit_ff),
      .cmd             (cmd),
      .status          (status),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .out_pair        (out_pair),
      .out_valid_count (out_valid_count),
      .out_last        (rsp_tlast),
      .limit_reached   (rsp_tuser)
   );

   assign rsp_tdata = {{(rld_pkg::RspDataWidth-rld_pkg::PairWidth-rld_pkg::VcntWidth){1'b0}},
                       out_valid_count, out_pair};

endmodule
`default_nettype wire
